@@ rtl/brus_pkg.sv @@
`default_nettype none

package brus_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int MW        = DW + 1;
    localparam int PW        = 2 * MW;
    localparam int SW        = DW + 4;

    localparam logic signed [DW-1:0] Q_ONE       = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DW-1:0] Q_THREE     = 32'sd3 <<< FRAC_BITS;
    localparam logic        [DW-1:0] COEFF_RESET = 32'd13370655;
    localparam logic signed [DW-1:0] S32_MAX     = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] S32_MIN     = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAP,
        ST_MSQ,
        ST_MDU,
        ST_MUUV,
        ST_MDV,
        ST_OUT
    } t_state;

    // operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MS_UU,
        MS_CLU,
        MS_SQV,
        MS_CLV
    } t_mul_sel;

    // where the scaled product of the previous cycle goes
    typedef enum logic [2:0] {
        D_NONE,
        D_SQ,
        D_DIFFU,
        D_UUV,
        D_DIFFV
    } t_dst;

    typedef struct packed {
        logic     load_cen;
        logic     load_new;
        logic     shift_win;
        logic     clear_win;
        logic     right_bound;
        logic     lap_en;
        t_mul_sel mul_sel;
        t_dst     dst;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

    function automatic logic signed [SW-1:0] sx36(input logic signed [DW-1:0] x);
        return {{(SW-DW){x[DW-1]}}, x};
    endfunction

    // clamp a wide signed value to 32 bits
    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] x);
        logic signed [DW-1:0] res;
        if (x[PW-1:DW-1] == '0 || x[PW-1:DW-1] == '1) begin
            res = x[DW-1:0];
        end else if (x[PW-1]) begin
            res = S32_MIN;
        end else begin
            res = S32_MAX;
        end
        return res;
    endfunction

    function automatic logic signed [PW-1:0] sx66(input logic signed [SW-1:0] x);
        return {{(PW-SW){x[SW-1]}}, x};
    endfunction

endpackage

`default_nettype wire

@@ rtl/brusselator_line_derivative_stream_core.sv @@
`default_nettype none

// channel   dir  tdata (low bit up)              tuser  tlast
// s_axis    in   u_value[31:0], v_value[31:0]    -      last_point
// m_axis    out  du_value[31:0], dv_value[31:0]  -      last_result
// cfg       in   stencil_coeff on i_cfg_wdata when i_cfg_we is high
//
// a point with no held center becomes the center and gives no result unless it closes the line
// each result uses the one shared 33x33 multiplier for four products
// a marked point after a held center gives two results, the second at the right boundary
// reset (synchronous, active low) empties the window and sets the coefficient
// a result waiting on m_axis stalls only the next result, not the next input

module brusselator_line_derivative_stream_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stencil coefficient write
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    // grid points in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // u_value[31:0], v_value[63:32]
    input  wire logic        s_axis_tlast,
    // derivatives out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // du_value[31:0], dv_value[63:32]
    output logic             m_axis_tlast
);
    import brus_pkg::*;

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic signed [DW-1:0] w_du, w_dv;

    // sequencer: window moves and multiplier schedule
    brus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // window, shared multiplier, sums and output register
    brus_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_u      (s_axis_tdata[31:0]),
        .i_in_v      (s_axis_tdata[63:32]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_du        (w_du),
        .o_dv        (w_dv),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {w_dv, w_du};

`ifndef NO_ASSERTIONS
    // a loaded result shows up on the output
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("result load did not raise m_axis_tvalid");

    // the square is captured only right after the laplacians start the schedule
    a_sched_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.dst == D_SQ) |-> $past(w_cmd.lap_en))
        else $error("multiplier schedule out of order");

    // no evaluation work overlaps taking a new beat
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (w_cmd.dst == D_NONE) && !w_cmd.out_load && !w_cmd.lap_en)
        else $error("input taken while a result is in progress");
`endif

endmodule

`default_nettype wire

@@ rtl/brus_ctrl.sv @@
`default_nettype none

module brus_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_ready,
    input  wire brus_pkg::t_dp_stat i_stat,
    output brus_pkg::t_dp_cmd       o_cmd
);
    import brus_pkg::*;

    t_state r_state, n_state;
    logic   r_held, n_held;    // a center point is waiting for its right neighbor
    logic   r_last, n_last;    // the newest point closes the line
    logic   r_end, n_end;      // current evaluation uses the right boundary

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= 1'b0;
            r_last  <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_last  <= n_last;
            r_end   <= n_end;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_held            = r_held;
        n_last            = r_last;
        n_end             = r_end;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        o_cmd.mul_sel     = MS_UU;
        o_cmd.dst         = D_NONE;
        o_cmd.right_bound = r_end;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_held) begin
                        o_cmd.load_new = 1'b1;
                        n_last         = i_in_last;
                        n_end          = 1'b0;
                        n_state        = ST_LAP;
                    end else begin
                        o_cmd.load_cen = 1'b1;
                        n_held         = 1'b1;
                        if (i_in_last) begin
                            n_last  = 1'b1;
                            n_end   = 1'b1;
                            n_state = ST_LAP;
                        end
                    end
                end
            end
            ST_LAP: begin
                o_cmd.lap_en  = 1'b1;
                o_cmd.mul_sel = MS_UU;
                n_state       = ST_MSQ;
            end
            ST_MSQ: begin
                o_cmd.dst     = D_SQ;
                o_cmd.mul_sel = MS_CLU;
                n_state       = ST_MDU;
            end
            ST_MDU: begin
                o_cmd.dst     = D_DIFFU;
                o_cmd.mul_sel = MS_SQV;
                n_state       = ST_MUUV;
            end
            ST_MUUV: begin
                o_cmd.dst     = D_UUV;
                o_cmd.mul_sel = MS_CLV;
                n_state       = ST_MDV;
            end
            ST_MDV: begin
                o_cmd.dst = D_DIFFV;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    if (r_end) begin
                        o_cmd.clear_win = 1'b1;
                        n_held          = 1'b0;
                        n_last          = 1'b0;
                        n_end           = 1'b0;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.shift_win = 1'b1;
                        if (r_last) begin
                            n_end   = 1'b1;
                            n_state = ST_LAP;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/brus_dp.sv @@
`default_nettype none

module brus_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire brus_pkg::t_dp_cmd          i_cmd,
    output brus_pkg::t_dp_stat              o_stat,
    input  wire logic signed [31:0]         i_in_u,
    input  wire logic signed [31:0]         i_in_v,
    input  wire logic                       i_cfg_we,
    input  wire logic [31:0]                i_cfg_wdata,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [31:0]              o_du,
    output logic signed [31:0]              o_dv,
    output logic                            o_last
);
    import brus_pkg::*;

    logic        [DW-1:0] r_coeff;
    logic signed [DW-1:0] r_left_u, r_left_v, r_cen_u, r_cen_v;
    logic signed [DW-1:0] r_new_u, r_new_v;
    logic signed [DW-1:0] r_lapu, r_lapv;
    logic signed [DW-1:0] r_sq, r_uuv, r_diffu, r_diffv;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_du, r_dv;
    logic                 r_out_valid, r_out_last;

    logic signed [DW-1:0] w_right_u, w_right_v;
    logic signed [SW-1:0] w_lapu_sum, w_lapv_sum;
    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_mprod;
    logic signed [DW-1:0] w_scaled;
    logic signed [SW-1:0] w_du_sum, w_dv_sum;

    // stencil window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff  <= COEFF_RESET;
            r_cen_u  <= '0;
            r_cen_v  <= '0;
            r_left_u <= Q_ONE;
            r_left_v <= Q_THREE;
        end else begin
            if (i_cfg_we) begin
                r_coeff <= i_cfg_wdata;
            end
            if (i_cmd.load_cen) begin
                r_cen_u <= i_in_u;
                r_cen_v <= i_in_v;
            end else if (i_cmd.shift_win) begin
                r_left_u <= r_cen_u;
                r_left_v <= r_cen_v;
                r_cen_u  <= r_new_u;
                r_cen_v  <= r_new_v;
            end else if (i_cmd.clear_win) begin
                r_cen_u  <= '0;
                r_cen_v  <= '0;
                r_left_u <= Q_ONE;
                r_left_v <= Q_THREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_new) begin
            r_new_u <= i_in_u;
            r_new_v <= i_in_v;
        end
    end

    assign w_right_u = i_cmd.right_bound ? Q_ONE   : r_new_u;
    assign w_right_v = i_cmd.right_bound ? Q_THREE : r_new_v;

    assign w_lapu_sum = sx36(r_left_u) - (sx36(r_cen_u) <<< 1) + sx36(w_right_u);
    assign w_lapv_sum = sx36(r_left_v) - (sx36(r_cen_v) <<< 1) + sx36(w_right_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lap_en) begin
            r_lapu <= sat32(sx66(w_lapu_sum));
            r_lapv <= sat32(sx66(w_lapv_sum));
        end
    end

    // shared multiplier, 33 x 33 signed
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_UU: begin
                w_ma = {r_cen_u[DW-1], r_cen_u};
                w_mb = {r_cen_u[DW-1], r_cen_u};
            end
            MS_CLU: begin
                w_ma = {1'b0, r_coeff};
                w_mb = {r_lapu[DW-1], r_lapu};
            end
            MS_SQV: begin
                w_ma = {r_sq[DW-1], r_sq};
                w_mb = {r_cen_v[DW-1], r_cen_v};
            end
            MS_CLV: begin
                w_ma = {1'b0, r_coeff};
                w_mb = {r_lapv[DW-1], r_lapv};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mprod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mprod;
    end

    // floor shift then clamp
    assign w_scaled = sat32(r_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.dst)
            D_NONE:  ;
            D_SQ:    r_sq    <= w_scaled;
            D_DIFFU: r_diffu <= w_scaled;
            D_UUV:   r_uuv   <= w_scaled;
            D_DIFFV: r_diffv <= w_scaled;
            default: ;
        endcase
    end

    assign w_du_sum = sx36(Q_ONE) + sx36(r_uuv) - (sx36(r_cen_u) <<< 2) + sx36(r_diffu);
    assign w_dv_sum = (sx36(r_cen_u) <<< 1) + sx36(r_cen_u) - sx36(r_uuv) + sx36(r_diffv);

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_du       <= sat32(sx66(w_du_sum));
            r_dv       <= sat32(sx66(w_dv_sum));
            r_out_last <= i_cmd.right_bound;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_full = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_du            = r_du;
    assign o_dv            = r_dv;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire
